/* rtl/met_pkg.sv */
`default_nettype none

package met_pkg;

    // Fixed-point value format: 32-bit two's complement
    localparam int VAL_BITS    = 32;
    localparam int STEP_BITS   = 31;
    localparam int RADIUS_BITS = 31;

    // Configuration port
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_STEP = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_RE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_IM  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS_SQ  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITER   = 3'd4;

    // Defaults for the top-level parameters
    localparam int DEFAULT_COORD_BITS = 12;
    localparam int DEFAULT_ITER_BITS  = 16;
    localparam int DEFAULT_FRAC_BITS  = 28;

    // Register reset values
    localparam logic [STEP_BITS-1:0]   RESET_PIXEL_STEP = 31'd1342177;
    localparam logic [RADIUS_BITS-1:0] RESET_RADIUS_SQ  = 31'd1073741824;
    localparam int                     RESET_MAX_ITER   = 256;

    localparam logic signed [VAL_BITS-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_BITS-1:0] VAL_MIN = 32'sh8000_0000;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch coordinate, form x*step and y*step
        logic map_c;     // add origin, clear z and count
        logic mul;       // register re*re, im*im, re*im
        logic advance;   // z = z*z + c, count += 1
        logic finish;    // load output register
    } met_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic go;        // |z|^2 below radius and count below limit
    } met_status_t;

    function automatic logic signed [VAL_BITS-1:0] sat_33(input logic signed [VAL_BITS:0] v);
        logic signed [VAL_BITS-1:0] r;
        if (v[VAL_BITS] != v[VAL_BITS-1])
            r = v[VAL_BITS] ? VAL_MIN : VAL_MAX;
        else
            r = v[VAL_BITS-1:0];
        return r;
    endfunction

    function automatic logic signed [VAL_BITS-1:0] sat_64(input logic signed [63:0] v);
        logic [63-VAL_BITS+1:0]     hi;
        logic signed [VAL_BITS-1:0] r;
        hi = v[63:VAL_BITS-1];
        if ((&hi) || !(|hi))
            r = v[VAL_BITS-1:0];
        else
            r = v[63] ? VAL_MIN : VAL_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/met_datapath.sv */
`default_nettype none

module met_datapath #(
    parameter int COORD_BITS = met_pkg::DEFAULT_COORD_BITS,
    parameter int ITER_BITS  = met_pkg::DEFAULT_ITER_BITS,
    parameter int FRAC_BITS  = met_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                                 clk,
    input  wire met_pkg::met_cmd_t                    cmd,
    output met_pkg::met_status_t                      status,
    input  wire logic [COORD_BITS-1:0]                pixel_x,
    input  wire logic [COORD_BITS-1:0]                pixel_y,
    input  wire logic [met_pkg::STEP_BITS-1:0]        pixel_step,
    input  wire logic signed [met_pkg::VAL_BITS-1:0]  origin_re,
    input  wire logic signed [met_pkg::VAL_BITS-1:0]  origin_im,
    input  wire logic [met_pkg::RADIUS_BITS-1:0]      escape_radius_sq,
    input  wire logic [ITER_BITS-1:0]                 max_iterations,
    output logic [COORD_BITS-1:0]                     out_x,
    output logic [COORD_BITS-1:0]                     out_y,
    output logic [ITER_BITS-1:0]                      color_index
);
    import met_pkg::*;

    localparam int PROD_BITS = COORD_BITS + STEP_BITS;   // x*step, unsigned
    localparam int MAP_BITS  = PROD_BITS + 2;            // plus signed origin
    localparam int SQ_BITS   = 2 * VAL_BITS - 1;         // re*re, non-negative
    localparam int LIM_BITS  = (RADIUS_BITS + FRAC_BITS > 2 * VAL_BITS) ?
                               RADIUS_BITS + FRAC_BITS : 2 * VAL_BITS;

    logic [COORD_BITS-1:0]       coord_x_reg, coord_y_reg;
    logic [PROD_BITS-1:0]        prod_x_reg, prod_y_reg;
    logic signed [VAL_BITS-1:0]  c_re_reg, c_im_reg;
    logic signed [VAL_BITS-1:0]  re_reg, im_reg;
    logic [SQ_BITS-1:0]          rr_reg, ii_reg;
    logic signed [63:0]          ri_reg;
    logic [ITER_BITS-1:0]        count_reg;
    logic [COORD_BITS-1:0]       out_x_reg, out_y_reg;
    logic [ITER_BITS-1:0]        color_reg;

    logic signed [MAP_BITS-1:0]  map_re, map_im;
    logic signed [VAL_BITS-1:0]  c_re_next, c_im_next;
    logic signed [63:0]          rr_full, ii_full, ri_full;
    logic [SQ_BITS-1:0]          rr_sh, ii_sh;
    logic signed [VAL_BITS-1:0]  rr_q, ii_q, diff_q, re_next, im_next, ri_q;
    logic signed [63:0]          ri_sh;
    logic [LIM_BITS-1:0]         mag_sum, mag_lim;
    logic [ITER_BITS-1:0]        count_next;

    function automatic logic signed [VAL_BITS-1:0] sat_map(input logic signed [MAP_BITS-1:0] v);
        logic [MAP_BITS-VAL_BITS:0] hi;
        logic signed [VAL_BITS-1:0] r;
        hi = v[MAP_BITS-1:VAL_BITS-1];
        if ((&hi) || !(|hi))
            r = v[VAL_BITS-1:0];
        else
            r = v[MAP_BITS-1] ? VAL_MIN : VAL_MAX;
        return r;
    endfunction

    // c = coordinate*step + origin, saturated
    always_comb
    begin
        map_re    = $signed({2'b00, prod_x_reg})
                  + $signed({{(MAP_BITS-VAL_BITS){origin_re[VAL_BITS-1]}}, origin_re});
        map_im    = $signed({2'b00, prod_y_reg})
                  + $signed({{(MAP_BITS-VAL_BITS){origin_im[VAL_BITS-1]}}, origin_im});
        c_re_next = sat_map(map_re);
        c_im_next = sat_map(map_im);
    end

    // products (registered before use)
    always_comb
    begin
        rr_full = re_reg * re_reg;
        ii_full = im_reg * im_reg;
        ri_full = re_reg * im_reg;
    end

    // z*z + c from registered products; squares are non-negative so floor is a plain shift
    always_comb
    begin
        rr_sh   = rr_reg >> FRAC_BITS;
        ii_sh   = ii_reg >> FRAC_BITS;
        rr_q    = (|rr_sh[SQ_BITS-1:VAL_BITS-1]) ? VAL_MAX : $signed(rr_sh[VAL_BITS-1:0]);
        ii_q    = (|ii_sh[SQ_BITS-1:VAL_BITS-1]) ? VAL_MAX : $signed(ii_sh[VAL_BITS-1:0]);
        diff_q  = sat_33({rr_q[VAL_BITS-1], rr_q} - {ii_q[VAL_BITS-1], ii_q});
        re_next = sat_33({diff_q[VAL_BITS-1], diff_q} + {c_re_reg[VAL_BITS-1], c_re_reg});
        ri_sh   = ri_reg >>> (FRAC_BITS - 1);
        ri_q    = sat_64(ri_sh);
        im_next = sat_33({ri_q[VAL_BITS-1], ri_q} + {c_im_reg[VAL_BITS-1], c_im_reg});
    end

    // escape test without saturation: floor(s / 2^F) < R  <=>  s < R * 2^F
    always_comb
    begin
        mag_sum    = LIM_BITS'(rr_reg) + LIM_BITS'(ii_reg);
        mag_lim    = LIM_BITS'(escape_radius_sq) << FRAC_BITS;
        status.go  = (mag_sum < mag_lim) && (count_reg < max_iterations);
        count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            coord_x_reg <= pixel_x;
            coord_y_reg <= pixel_y;
            prod_x_reg  <= PROD_BITS'(pixel_x) * PROD_BITS'(pixel_step);
            prod_y_reg  <= PROD_BITS'(pixel_y) * PROD_BITS'(pixel_step);
        end
        if (cmd.map_c)
        begin
            c_re_reg  <= c_re_next;
            c_im_reg  <= c_im_next;
            re_reg    <= '0;
            im_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.advance)
        begin
            re_reg    <= re_next;
            im_reg    <= im_next;
            count_reg <= count_next;
        end
        if (cmd.mul)
        begin
            rr_reg <= rr_full[SQ_BITS-1:0];
            ii_reg <= ii_full[SQ_BITS-1:0];
            ri_reg <= ri_full;
        end
        if (cmd.finish)
        begin
            out_x_reg <= coord_x_reg;
            out_y_reg <= coord_y_reg;
            color_reg <= (count_reg == '0) ? '0 : count_reg - 1'b1;
        end
    end

    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign color_index = color_reg;

endmodule

`default_nettype wire

/* rtl/met_ctrl.sv */
`default_nettype none

module met_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output met_pkg::met_cmd_t          cmd,
    input  wire met_pkg::met_status_t  status
);
    import met_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_STEP
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   out_free;

    assign accept   = in_valid && in_ready_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd         = '0;
        cmd.capture = accept;
        cmd.map_c   = (state_reg == ST_MAP);
        cmd.mul     = (state_reg == ST_MUL);
        cmd.advance = (state_reg == ST_STEP) && status.go;
        cmd.finish  = (state_reg == ST_STEP) && !status.go && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a result taken in the same cycle a new one loads keeps valid high
            if (out_valid_reg && out_ready && !cmd.finish)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        in_ready_reg <= 1'b0;
                        state_reg    <= ST_MAP;
                    end
                end
                ST_MAP:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    if (status.go)
                        state_reg <= ST_MUL;
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        in_ready_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/mandelbrot_escape_time.sv */
`default_nettype none

// Mandelbrot escape-time engine. Each input transaction carries one pixel
// coordinate (pixel_x, pixel_y); the block maps it to c = (x*step + origin_re,
// y*step + origin_im), iterates z = z*z + c from z = 0 while |z|^2 is below
// escape_radius_sq and the count is below max_iterations, and returns one
// output transaction with the coordinate echoed and color_index = count - 1
// (0 when no iteration ran). Values are signed 32-bit fixed point with
// FRAC_BITS fraction bits; products and sums saturate. One pixel is in flight
// at a time. From acceptance the block maps c, then for each iteration
// registers the products of the three 32x32 multipliers and then does the
// saturating add and escape compare, and ends with a final multiply and a
// compare that loads the result register. in_ready returns in the same cycle
// that the result loads. A finished result sits in the output register while
// the next pixel is accepted and worked on; if that register is still held
// when the next pixel finishes, the engine waits with in_ready low until the
// result is taken. Configuration registers (pixel_step, origin_re, origin_im,
// escape_radius_sq, max_iterations at indexes 0..4) are written through
// cfg_write_en/cfg_index/cfg_data while the block is idle; the block itself
// does not enforce this, so the user must keep to it. Writes to other indexes
// are dropped.

module mandelbrot_escape_time #(
    parameter int COORD_BITS = met_pkg::DEFAULT_COORD_BITS,
    parameter int ITER_BITS  = met_pkg::DEFAULT_ITER_BITS,
    parameter int FRAC_BITS  = met_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_write_en,
    input  wire logic [met_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [met_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // pixel input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [COORD_BITS-1:0]               pixel_x,
    input  wire logic [COORD_BITS-1:0]               pixel_y,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [COORD_BITS-1:0]                    out_x,
    output logic [COORD_BITS-1:0]                    out_y,
    output logic [ITER_BITS-1:0]                     color_index
);
    import met_pkg::*;

    logic [STEP_BITS-1:0]        pixel_step_reg;
    logic signed [VAL_BITS-1:0]  origin_re_reg;
    logic signed [VAL_BITS-1:0]  origin_im_reg;
    logic [RADIUS_BITS-1:0]      radius_sq_reg;
    logic [ITER_BITS-1:0]        max_iter_reg;

    met_cmd_t    cmd;
    met_status_t status;

    // Register file; upper data bits beyond each register's width are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_step_reg <= RESET_PIXEL_STEP;
            origin_re_reg  <= '0;
            origin_im_reg  <= '0;
            radius_sq_reg  <= RESET_RADIUS_SQ;
            max_iter_reg   <= ITER_BITS'(RESET_MAX_ITER);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PIXEL_STEP: pixel_step_reg <= cfg_data[STEP_BITS-1:0];
                REG_ORIGIN_RE:  origin_re_reg  <= $signed(cfg_data[VAL_BITS-1:0]);
                REG_ORIGIN_IM:  origin_im_reg  <= $signed(cfg_data[VAL_BITS-1:0]);
                REG_RADIUS_SQ:  radius_sq_reg  <= cfg_data[RADIUS_BITS-1:0];
                REG_MAX_ITER:   max_iter_reg   <= cfg_data[ITER_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer: accept -> map c -> (multiply, step)* -> result
    met_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Arithmetic: coordinate mapping, iteration registers, result register
    met_datapath #(
        .COORD_BITS (COORD_BITS),
        .ITER_BITS  (ITER_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk              (clk),
        .cmd              (cmd),
        .status           (status),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .pixel_step       (pixel_step_reg),
        .origin_re        (origin_re_reg),
        .origin_im        (origin_im_reg),
        .escape_radius_sq (radius_sq_reg),
        .max_iterations   (max_iter_reg),
        .out_x            (out_x),
        .out_y            (out_y),
        .color_index      (color_index)
    );

endmodule

`default_nettype wire
